// File: rtl/fdl_pkg.sv
// Package for the fractional delay line: field widths, command codes,
// default sizes and the register reset value.
// No dependencies; every other file of the block but fdl_ram imports it.
package fdl_pkg;

  localparam int CMD_W       = 2;
  localparam int SAMPLE_W    = 24;  // width of the sample fields on the ports
  localparam int DELAY_MS_W  = 18;  // unsigned Q10.8
  localparam int DELAY_SMP_W = 14;
  localparam int SPMS_W      = 24;  // unsigned, 16 fraction bits
  localparam int PROD_W      = DELAY_MS_W + SPMS_W;
  localparam int FRAC_W      = 16;

  localparam int DEPTH_DEF       = 16384;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam logic [SPMS_W-1:0] SPMS_RESET = 24'd3145728;  // 48 samples per ms

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ_MS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_SM = 2'd2;

endpackage

// File: rtl/fdl_if.sv
// Valid/ready channel interfaces of the fractional delay line.
// Depends on fdl_pkg for the field widths.
interface fdl_in_if import fdl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic signed [SAMPLE_W-1:0]    sample_in;
  logic [DELAY_MS_W-1:0]         delay_ms;
  logic [DELAY_SMP_W-1:0]        delay_samples;
  logic                          interpolate;

  modport source (output valid, cmd, sample_in, delay_ms, delay_samples, interpolate,
                  input ready);
  modport sink   (input valid, cmd, sample_in, delay_ms, delay_samples, interpolate,
                  output ready);
endinterface

interface fdl_out_if import fdl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// File: rtl/fdl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fractional_delay_line_unit.sv
// Fractional delay line, top level.
// Depends on fdl_pkg, the channel interfaces in fdl_if and the RAM fdl_ram.
//
// An audio delay line held in a circular store of DEPTH samples (a power of
// two) in one synchronous RAM. A write word (cmd 0) moves the write pointer
// on by one, with wrap, and stores the sample there; it gives no result. A
// read word returns the sample at write pointer minus one minus the delay,
// wrapped modulo DEPTH. Cmd 2 gives the delay in whole samples. Cmd 1 gives
// it in milliseconds (Q10.8), multiplied by the samples_per_ms register
// (Q8.16); with interpolate set the result blends linearly toward the next
// older sample using the 16-bit fraction of that product, rounding toward
// minus infinity. Cmd 3 is taken and ignored. The store reads as all zeros
// after reset without a clearing pass: a saturating fill count tracks which
// entries have been written since reset, and an unwritten entry reads as
// zero. The block handles one word at a time; every read goes through the
// single read port of the RAM. A write or cmd 3 completes as it is accepted.
// A sample read reads the RAM, a millisecond read multiplies and then reads,
// and an interpolated read adds a second RAM read, the multiply of the
// difference by the fraction and the blend add. The input is accepted again
// as soon as a result has moved into the output register, which holds it
// until the sink takes it. The configuration register may be written only
// while no read is in progress.
module fractional_delay_line_unit import fdl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fdl_in_if.sink            in_ch,
  fdl_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [SPMS_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(DEPTH);
  localparam int SB  = SAMPLE_BITS;
  // Working widths for extending the delays and samples to the wider side.
  localparam int MSW = (AW > DELAY_MS_W) ? AW : DELAY_MS_W;
  localparam int SMW = (AW > DELAY_SMP_W) ? AW : DELAY_SMP_W;
  localparam int XSW = (SB > SAMPLE_W) ? SB : SAMPLE_W;
  localparam int MW  = SB + FRAC_W + 2;  // (b - a) times unsigned fraction

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RDA,
    S_RDB,
    S_BLEND,
    S_OUT
  } state_t;

  // Control registers.
  state_t            state_r,     state_nxt;
  logic [AW-1:0]     wp_r,        wp_nxt;
  logic [AW:0]       fill_r,      fill_nxt;
  logic [SPMS_W-1:0] spms_r,      spms_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [PROD_W-1:0]       p_r,       p_nxt;
  logic [AW-1:0]           idx_r,     idx_nxt;
  logic                    interp_r,  interp_nxt;
  logic                    rd_vld_r,  rd_vld_nxt;
  logic signed [SB-1:0]    a_r,       a_nxt;
  logic signed [MW-1:0]    prod_r,    prod_nxt;
  logic signed [SB-1:0]    res_r,     res_nxt;
  logic [SAMPLE_W-1:0]     out_data_r, out_data_nxt;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SB-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SB-1:0] ram_rdata;

  logic                 in_acc;
  logic [MSW-1:0]       ms_delay;
  logic [SMW-1:0]       smp_delay;
  logic [AW-1:0]        ms_idx;
  logic [AW-1:0]        smp_idx;
  logic [AW-1:0]        older_idx;
  logic [XSW-1:0]       sample_ext;
  logic signed [SB-1:0] rd_sample;
  logic signed [SB:0]   diff;
  logic signed [MW-1:0] blend_sum;
  logic signed [XSW-1:0] res_ext;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // Read addresses: write pointer minus one minus the delay, wrapped.
  assign ms_delay  = MSW'(p_r[PROD_W-1:PROD_W-DELAY_MS_W]);
  assign smp_delay = SMW'(in_ch.delay_samples);
  assign ms_idx    = wp_r - AW'(1) - ms_delay[AW-1:0];
  assign smp_idx   = wp_r - AW'(1) - smp_delay[AW-1:0];
  assign older_idx = idx_r - AW'(1);

  // The input field is taken as raw bits, zero-extended if needed, and its low SB bits are stored.
  assign sample_ext = XSW'($unsigned(in_ch.sample_in));

  // An entry not written since reset reads as zero.
  assign rd_sample = rd_vld_r ? $signed(ram_rdata) : '0;

  assign diff      = {rd_sample[SB-1], rd_sample} - {a_r[SB-1], a_r};
  assign blend_sum = MW'(a_r) + (prod_r >>> FRAC_W);
  assign res_ext   = XSW'(res_r);

  // Entry i has been written since reset when ((i - 1) mod DEPTH) < fill.
  function automatic logic entry_written(logic [AW-1:0] idx, logic [AW:0] fill);
    logic [AW-1:0] off;
    off = idx - AW'(1);
    return {1'b0, off} < fill;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    spms_nxt      = spms_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    interp_nxt    = interp_r;
    rd_vld_nxt    = rd_vld_r;
    a_nxt         = a_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r + AW'(1);
    ram_wdata     = sample_ext[SB-1:0];
    ram_re        = 1'b0;
    ram_raddr     = smp_idx;

    if (cfg_we) begin
      spms_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.cmd)
            CMD_WRITE: begin
              ram_we = 1'b1;
              wp_nxt = wp_r + AW'(1);
              if (fill_r != (AW + 1)'(DEPTH)) begin
                fill_nxt = fill_r + (AW + 1)'(1);
              end
            end
            CMD_READ_MS: begin
              p_nxt      = PROD_W'(in_ch.delay_ms) * PROD_W'(spms_r);
              interp_nxt = in_ch.interpolate;
              state_nxt  = S_MUL;
            end
            CMD_READ_SM: begin
              ram_re     = 1'b1;
              ram_raddr  = smp_idx;
              rd_vld_nxt = entry_written(smp_idx, fill_r);
              interp_nxt = 1'b0;
              state_nxt  = S_RDA;
            end
            default: begin
              // Unused command: taken, no effect.
            end
          endcase
        end
      end
      S_MUL: begin
        ram_re     = 1'b1;
        ram_raddr  = ms_idx;
        idx_nxt    = ms_idx;
        rd_vld_nxt = entry_written(ms_idx, fill_r);
        state_nxt  = S_RDA;
      end
      S_RDA: begin
        a_nxt = rd_sample;
        if (interp_r) begin
          ram_re     = 1'b1;
          ram_raddr  = older_idx;
          rd_vld_nxt = entry_written(older_idx, fill_r);
          state_nxt  = S_RDB;
        end else begin
          res_nxt   = rd_sample;
          state_nxt = S_OUT;
        end
      end
      S_RDB: begin
        prod_nxt  = MW'(diff) * MW'($signed({1'b0, p_r[FRAC_W+7:8]}));
        state_nxt = S_BLEND;
      end
      S_BLEND: begin
        res_nxt   = blend_sum[SB-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_ext[SAMPLE_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      spms_r      <= SPMS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      spms_r      <= spms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    idx_r      <= idx_nxt;
    interp_r   <= interp_nxt;
    rd_vld_r   <= rd_vld_nxt;
    a_r        <= a_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  fdl_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fractional_delay_line_unit: a clocked driver and monitor
// on the two valid/ready channels, checked against an in-bench model of the delay line.
// Depends on fdl_pkg, the fdl_in_if/fdl_out_if interfaces and the block's RTL.
module tb;
  import fdl_pkg::*;

  localparam int DEPTH            = DEPTH_DEF;
  localparam int IDX_W            = $clog2(DEPTH);
  localparam int WHOLE_LSB        = 24;    // Q10.8 times Q8.16 leaves 24 fraction bits
  localparam int CLK_HALF         = 6;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 12;    // time for trailing words to leave the block
  localparam int RANDOM_PER_PHASE = 100;
  localparam int BURST_WRITES     = 40;

  localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;
  localparam logic [SPMS_W-1:0]   SPMS_MAX   = 24'hFFFFFF;
  localparam logic [SPMS_W-1:0]   SPMS_44K1  = 24'd2890138;  // 44.1 samples per ms
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

  // One word of the input channel, as the driver presents it.
  typedef struct {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [DELAY_MS_W-1:0]      delay_ms;
    logic [DELAY_SMP_W-1:0]     delay_samples;
    logic                       interpolate;
  } dline_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SPMS_W-1:0] cfg_wdata;

  fdl_in_if  in_ch();
  fdl_out_if out_ch();

  fractional_delay_line_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the block: the circular sample store, its write pointer and the rate register.
  logic signed [SAMPLE_W-1:0] store_img [DEPTH];
  logic [IDX_W-1:0]           wr_ptr;
  logic [SPMS_W-1:0]          spms_q16;

  dline_word_t                pending_words [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  dline_word_t                shown_word;

  int words_queued  = 0;
  int words_taken   = 0;
  int reads_checked = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  int cfg_writes    = 0;
  int in_wait       = 0;
  int out_stall     = 0;
  bit in_steady     = 0;
  bit out_steady    = 0;
  bit gapless       = 0;

  // Advance the model by one accepted word. Writes bump the pointer and then store the
  // sample, so a read of delay zero lands one entry behind the newest sample. A millisecond
  // read scales the delay by the rate register; the whole part picks the entry and bits
  // 23..8 of the product blend toward the next older entry, rounding toward minus infinity.
  function automatic void apply_word(dline_word_t w);
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  ia;
    longint            a;
    longint            b;
    case (w.cmd)
      CMD_WRITE: begin
        wr_ptr = wr_ptr + IDX_W'(1);
        store_img[wr_ptr] = w.sample;
      end
      CMD_READ_MS: begin
        prod = PROD_W'(w.delay_ms) * PROD_W'(spms_q16);
        ia = wr_ptr - IDX_W'(1) - prod[WHOLE_LSB +: IDX_W];
        a = store_img[ia];
        if (w.interpolate) begin
          b = store_img[ia - IDX_W'(1)];
          a = a + (((b - a) * longint'(prod[WHOLE_LSB-FRAC_W +: FRAC_W])) >>> FRAC_W);
        end
        expected_samples.push_back(a[SAMPLE_W-1:0]);
      end
      CMD_READ_SM: begin
        // The interpolate flag has no effect on whole-sample reads.
        ia = wr_ptr - IDX_W'(1) - w.delay_samples;
        expected_samples.push_back(store_img[ia]);
      end
      default: begin
        // The unused command is taken and leaves everything as it was.
      end
    endcase
  endfunction

  function automatic void queue_word(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] sample,
                                     logic [DELAY_MS_W-1:0] dms,
                                     logic [DELAY_SMP_W-1:0] dsm, logic interp);
    dline_word_t w;
    w.cmd           = cmd;
    w.sample        = sample;
    w.delay_ms      = dms;
    w.delay_samples = dsm;
    w.interpolate   = interp;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Half the random words are writes so the store fills with content worth reading. Most
  // delays are short enough to land on recently written samples; the rest span the full
  // field and wrap around the store.
  function automatic void queue_random_words(int n);
    int                    pick;
    logic [CMD_W-1:0]      cmd;
    logic [SAMPLE_W-1:0]   sample;
    logic [DELAY_MS_W-1:0] dms;
    logic [DELAY_SMP_W-1:0] dsm;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        cmd = CMD_WRITE;
      else if (pick < 73)
        cmd = CMD_READ_MS;
      else if (pick < 95)
        cmd = CMD_READ_SM;
      else
        cmd = CMD_UNUSED;
      sample = SAMPLE_W'($urandom());
      if ($urandom_range(0, 9) == 0)
        sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      dms = ($urandom_range(0, 2) != 0) ? DELAY_MS_W'($urandom_range(0, 1023))
                                        : DELAY_MS_W'($urandom());
      dsm = ($urandom_range(0, 2) != 0) ? DELAY_SMP_W'($urandom_range(0, 63))
                                        : DELAY_SMP_W'($urandom());
      queue_word(cmd, sample, dms, dsm, 1'($urandom_range(0, 1)));
    end
  endfunction

  // The rate register may only change while no read is in flight.
  task automatic write_spms(input logic [SPMS_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    spms_q16 = value;
    cfg_writes++;
  endtask

  // Wait until every queued word has been taken and every read has come back, then give
  // trailing writes and ignored commands time to leave the block.
  task automatic settle();
    while (words_taken != words_queued || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Input driver. A word is predicted at the edge where it is accepted. After each word
  // the driver holds valid low for a random gap, except in steady stretches and
  // during the back-to-back write burst, where words follow with no gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.cmd           <= CMD_WRITE;
      in_ch.sample_in     <= '0;
      in_ch.delay_ms      <= '0;
      in_ch.delay_samples <= '0;
      in_ch.interpolate   <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_word(shown_word);
        words_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_wait > 0) begin
          in_ch.valid <= 1'b0;
          in_wait--;
        end else if (pending_words.size() > 0) begin
          shown_word = pending_words.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.cmd           <= shown_word.cmd;
          in_ch.sample_in     <= shown_word.sample;
          in_ch.delay_ms      <= shown_word.delay_ms;
          in_ch.delay_samples <= shown_word.delay_samples;
          in_ch.interpolate   <= shown_word.interpolate;
          if ($urandom_range(0, 31) == 0)
            in_steady = !in_steady;
          in_wait = (gapless || in_steady) ? 0 : $urandom_range(0, 7);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted word is compared with the oldest expected sample, then
  // ready drops for a random stall unless a steady stretch is running.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual sample_out %0d",
                   $time, out_ch.sample_out);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          reads_checked++;
          if (out_ch.sample_out !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, out_ch.sample_out);
            error_count++;
          end
        end
        if ($urandom_range(0, 31) == 0)
          out_steady = !out_steady;
        out_stall = out_steady ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reads outstanding",
               cycle_count, expected_samples.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [SPMS_W-1:0] rate_plan [4];

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = SPMS_RESET;
    wr_ptr              = '0;
    spms_q16            = SPMS_RESET;
    foreach (store_img[i])
      store_img[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset rate of 48 samples per ms. The first read sees only the
    // cleared store.
    queue_word(CMD_READ_SM, '0, '0, '0, 1'b0);
    queue_word(CMD_WRITE, 24'hAAAAAA, '0, '0, 1'b0);
    queue_word(CMD_WRITE, 24'h555555, '0, '0, 1'b0);
    queue_word(CMD_WRITE, SAMPLE_MAX, '0, '0, 1'b0);
    queue_word(CMD_WRITE, SAMPLE_MIN, '0, '0, 1'b0);
    queue_word(CMD_WRITE, 24'h000000, '0, '0, 1'b0);
    queue_word(CMD_WRITE, 24'h000001, '0, '0, 1'b0);
    queue_word(CMD_WRITE, 24'hFFFFFF, '0, '0, 1'b0);
    queue_word(CMD_READ_SM, '0, '0, 14'd0, 1'b0);
    // Whole-sample read with the interpolate flag set; the flag must be ignored.
    queue_word(CMD_READ_SM, '0, '0, 14'd4, 1'b1);
    // The largest whole-sample delay reaches back around the store.
    queue_word(CMD_READ_SM, '0, '0, 14'h3FFF, 1'b0);
    queue_word(CMD_UNUSED, SAMPLE_MIN, 18'h3FFFF, 14'h3FFF, 1'b1);
    queue_word(CMD_READ_MS, '0, 18'd0, '0, 1'b0);
    queue_word(CMD_READ_MS, '0, 18'd0, '0, 1'b1);
    // A fraction of a sample only, then blends between the two extremes in both
    // directions (most negative toward most positive, and most positive toward a
    // smaller value).
    queue_word(CMD_READ_MS, '0, 18'd1, '0, 1'b1);
    queue_word(CMD_READ_MS, '0, 18'd12, '0, 1'b1);
    queue_word(CMD_READ_MS, '0, 18'd17, '0, 1'b1);
    queue_word(CMD_READ_MS, '0, 18'h00080, '0, 1'b0);
    // The longest millisecond delay is far beyond the store depth and wraps.
    queue_word(CMD_READ_MS, '0, 18'h3FFFF, '0, 1'b1);
    queue_word(CMD_READ_MS, '0, 18'h2AAAA, '0, 1'b1);
    queue_word(CMD_READ_MS, '0, 18'h15555, '0, 1'b0);
    queue_word(CMD_READ_SM, '0, '0, 14'h2AAA, 1'b1);
    queue_word(CMD_READ_SM, '0, '0, 14'h1555, 1'b0);
    queue_random_words(RANDOM_PER_PHASE);
    settle();

    // Random traffic at the largest, smallest, a typical and a random rate.
    rate_plan    = '{SPMS_MAX, 24'd0, SPMS_44K1, SPMS_RESET};
    rate_plan[3] = SPMS_W'($urandom());
    foreach (rate_plan[i]) begin
      write_spms(rate_plan[i]);
      queue_random_words(RANDOM_PER_PHASE);
      settle();
    end

    // A burst of writes with no gap between them, then random traffic at the reset rate.
    gapless = 1'b1;
    repeat (BURST_WRITES)
      queue_word(CMD_WRITE, SAMPLE_W'($urandom()), '0, '0, 1'b0);
    settle();
    gapless = 1'b0;
    write_spms(SPMS_RESET);
    queue_random_words(RANDOM_PER_PHASE);
    settle();

    $display("Delay line run: %0d words taken, %0d delayed samples checked,",
             words_taken, reads_checked);
    $display("across %0d rate register writes and a burst of %0d back-to-back writes.",
             cfg_writes, BURST_WRITES);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
